[rtl/b2d_pkg.sv]
package b2d_pkg;

	localparam int MAX_DIGITS = 8;

	typedef logic [7:0] char_t;
	typedef logic [MAX_DIGITS-1:0][7:0] char_vec_t;
	typedef logic [3:0] count_t;

	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_DEC = 2'd2;
	localparam logic [1:0] BASE_HEX = 2'd3;

	localparam char_t CHAR_ZERO  = 8'd48;
	localparam char_t CHAR_A     = 8'd65;
	localparam char_t CHAR_SPACE = 8'd32;

	// reciprocal multipliers: x*41>>12 == x/100 for x<256, x*205>>11 == x/10 for x<100
	localparam logic [5:0] DIV100_MUL = 6'd41;
	localparam int         DIV100_SH  = 12;
	localparam logic [7:0] DIV10_MUL  = 8'd205;
	localparam int         DIV10_SH   = 11;
	localparam logic [6:0] HUNDRED    = 7'd100;
	localparam logic [3:0] TEN        = 4'd10;

	typedef struct packed {
		logic [7:0] code;
		logic [1:0] base;
	} s1_t;

	typedef struct packed {
		logic [7:0] code;
		logic [1:0] base;
		logic [1:0] q100;
		logic [6:0] rem;
	} s2_t;

	typedef struct packed {
		char_vec_t chars;
		count_t    ndig;
	} s3_t;

	function automatic char_t digit_char(input logic [3:0] d);
		if (d < TEN)
			return CHAR_ZERO + {4'd0, d};
		return CHAR_A + {4'd0, d - TEN};
	endfunction

endpackage

[rtl/b2d_div.sv]
module b2d_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  b2d_pkg::s1_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output b2d_pkg::s2_t out_data
);
	import b2d_pkg::*;

	logic        valid_s2;
	s2_t         data_s2;
	logic [13:0] prod;
	logic [1:0]  q100;
	logic [7:0]  sub;

	assign prod = 14'(in_data.code) * 14'(DIV100_MUL);
	assign q100 = prod[DIV100_SH+1:DIV100_SH];
	assign sub  = 8'(q100) * 8'(HUNDRED);

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (in_ready)
			valid_s2 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.code <= in_data.code;
			data_s2.base <= in_data.base;
			data_s2.q100 <= q100;
			data_s2.rem  <= 7'(in_data.code - sub);
		end
	end

endmodule

[rtl/b2d_fmt.sv]
module b2d_fmt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  b2d_pkg::s2_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output b2d_pkg::s3_t out_data
);
	import b2d_pkg::*;

	logic             valid_s3;
	s3_t              data_s3;
	logic [14:0]      prod;
	logic [3:0]       tens;
	logic [3:0]       ones;
	logic [3:0][3:0]  dl;      // digits, least significant first
	logic [1:0]       top_idx; // index of most significant digit
	logic [1:0]       sel;
	s3_t              nxt;

	assign prod = 15'(in_data.rem) * 15'(DIV10_MUL);
	assign tens = prod[DIV10_SH+3:DIV10_SH];
	assign ones = 4'(in_data.rem - 7'(tens * TEN));

	always_comb begin
		dl      = '0;
		top_idx = 2'd0;
		nxt     = '0;
		sel     = 2'd0;
		case (in_data.base)
			BASE_OCT: begin
				dl[0] = {1'b0, in_data.code[2:0]};
				dl[1] = {1'b0, in_data.code[5:3]};
				dl[2] = {2'b0, in_data.code[7:6]};
				if (in_data.code[7:6] != 2'd0)
					top_idx = 2'd2;
				else if (in_data.code[5:3] != 3'd0)
					top_idx = 2'd1;
			end
			BASE_DEC: begin
				dl[0] = ones;
				dl[1] = tens;
				dl[2] = {2'b0, in_data.q100};
				if (in_data.q100 != 2'd0)
					top_idx = 2'd2;
				else if (tens != 4'd0)
					top_idx = 2'd1;
			end
			default: begin
				dl[0] = in_data.code[3:0];
				dl[1] = in_data.code[7:4];
				if (in_data.code[7:4] != 4'd0)
					top_idx = 2'd1;
			end
		endcase

		if (in_data.base == BASE_BIN) begin
			for (int i = 0; i < MAX_DIGITS; i++)
				nxt.chars[i] = CHAR_ZERO + {7'd0, in_data.code[MAX_DIGITS-1-i]};
			nxt.ndig = count_t'(MAX_DIGITS);
		end else begin
			for (int i = 0; i < 4; i++) begin
				sel = top_idx - 2'(i);
				nxt.chars[i] = digit_char(dl[sel]);
			end
			nxt.ndig = {2'b0, top_idx} + 4'd1;
		end
	end

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (in_ready)
			valid_s3 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s3 <= nxt;
	end

endmodule

[rtl/b2d_ser.sv]
module b2d_ser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  b2d_pkg::s3_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_char,
	output logic         last_of_run
);
	import b2d_pkg::*;

	logic   busy_q;
	s3_t    cur_q;
	count_t idx_q;
	logic   at_space;

	assign at_space    = (idx_q == cur_q.ndig);
	assign out_valid   = busy_q;
	assign last_of_run = at_space;
	assign out_char    = at_space ? CHAR_SPACE : cur_q.chars[idx_q[2:0]];
	// next run loads as the trailing space leaves
	assign in_ready    = !busy_q || (out_ready && at_space);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			idx_q  <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			cur_q <= in_data;
	end

endmodule

[rtl/byte_to_base_digits_encoder.sv]
// A request passes the capture, divide and format registers and the serializer
// register before its first digit is presented. One character per cycle while
// out_ready is high; a binary request is eight digits plus a trailing space,
// octal/decimal 2 to 4 characters and hex 2 to 3, set by the output serializer.
// Three stages (capture, divide by 100, digit format) feed the serializer.
// arst_n clears all valid bits and the latched base to binary.
module byte_to_base_digits_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] base_select
);
	import b2d_pkg::*;

	logic [1:0] base_q;
	logic       valid_s1;
	s1_t        data_s1;
	logic       rdy_div;
	logic       v_div;
	s2_t        d_div;
	logic       rdy_fmt;
	logic       v_fmt;
	s3_t        d_fmt;
	logic       rdy_ser;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || rdy_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_BIN;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid)
				base_q <= base_select;
			if (in_ready)
				valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.code <= char_code;
			data_s1.base <= base_q;
		end
	end

	b2d_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (rdy_div),
		.in_data   (data_s1),
		.out_valid (v_div),
		.out_ready (rdy_fmt),
		.out_data  (d_div)
	);

	b2d_fmt u_fmt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_div),
		.in_ready  (rdy_fmt),
		.in_data   (d_div),
		.out_valid (v_fmt),
		.out_ready (rdy_ser),
		.out_data  (d_fmt)
	);

	b2d_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_fmt),
		.in_ready    (rdy_ser),
		.in_data     (d_fmt),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule
